/* hw/rtl/char_cell_draw_engine_defines.svh */
// ---------------------------------------------------------------------------
// Character-cell draw engine: assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef CHAR_CELL_DRAW_ENGINE_DEFINES_SVH
`define CHAR_CELL_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication
`define CCDE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ccde_pkg.sv */
// ---------------------------------------------------------------------------
// Character-cell draw engine package
// Shared types, command codes and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package ccde_pkg;

   localparam int CoordWidth = 12;
   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [2:0] {
      OP_READ       = 3'd0,
      OP_FG_RECT    = 3'd1,
      OP_BLOCK_RECT = 3'd2,
      OP_BG_RECT    = 3'd3,
      OP_DISC       = 3'd4,
      OP_FG_SPAN    = 3'd5
   } op_type;

   localparam logic [7:0] SOLID_BLOCK = 8'd219;

   localparam logic [0:0] CSR_COLS = 1'b0;
   localparam logic [0:0] CSR_ROWS = 1'b1;

   localparam logic [6:0] COLS_RESET = 7'd80;
   localparam logic [4:0] ROWS_RESET = 5'd25;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
      logic clear;
      logic rsp_load;
   } ccde_cmd_type;

   typedef struct packed {
      logic area_empty;
      logic box_empty;
      logic walk_last;
      logic clear_last;
      logic rsp_free;
   } ccde_status_type;

endpackage

/* hw/rtl/char_cell_draw_engine.sv */
// ---------------------------------------------------------------------------
// Character-cell draw engine
// Text-mode cell store with read, rectangle, disc and span drawing commands.
// ---------------------------------------------------------------------------
// After reset the store's MAX_COLS*MAX_ROWS cells (2000 at default size)
// are cleared one cell per cycle, with req_tready low; csr writes are
// taken throughout. A read passes an address and a data state and loads
// its response once the response register is free. Rectangle and disc
// commands set up and check the clipped bounding box, then walk it
// ((2*radius+1)^2 cells at most for a disc) and drain; an empty box goes
// back to idle after the check. A span walks with no setup, plus one step
// that paints nothing when it stops early at the edge of the area or has
// zero length. The walk read-modify-writes the store, one cell per cycle.
// Drawing commands on an empty area, and op codes 6 and 7, stay in idle.
module char_cell_draw_engine import ccde_pkg::*; #(
   parameter int MAX_COLS = 80,
   parameter int MAX_ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // color[3:0], glyph[11:4], x_a[21:12], y_a[31:22], x_b[41:32],
   // y_b[51:42], radius[57:52], span_length[68:58], zero[71:69]
   input  logic [71:0] req_tdata,
   // op[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_glyph[7:0], cell_fg[11:8], cell_bg[15:12]
   output logic [15:0] rsp_tdata,
   // in_range[0]
   output logic        rsp_tuser
);

   ccde_cmd_type    cmd;
   ccde_status_type status;

   ccde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .status     (status),
      .cmd        (cmd)
   );

   ccde_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_op          (op_type'(req_tuser)),
      .req_color       (req_tdata[3:0]),
      .req_glyph       (req_tdata[11:4]),
      .req_x_a         (req_tdata[21:12]),
      .req_y_a         (req_tdata[31:22]),
      .req_x_b         (req_tdata[41:32]),
      .req_y_b         (req_tdata[51:42]),
      .req_radius      (req_tdata[57:52]),
      .req_span_length (req_tdata[68:58]),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_cell_glyph  (rsp_tdata[7:0]),
      .rsp_cell_fg     (rsp_tdata[11:8]),
      .rsp_cell_bg     (rsp_tdata[15:12]),
      .rsp_in_range    (rsp_tuser)
   );

endmodule

/* hw/rtl/ccde_ctrl.sv */
// ---------------------------------------------------------------------------
// Character-cell draw engine: controller
// Sequences clearing, command setup, the cell walk and read responses.
// ---------------------------------------------------------------------------
module ccde_ctrl import ccde_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  op_type          req_op,
   input  ccde_status_type status,
   output ccde_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_WALK,
      ST_DRAIN,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (req_op) inside
                  OP_READ: state_in = ST_RD_ADDR;
                  OP_FG_RECT, OP_BLOCK_RECT, OP_BG_RECT, OP_DISC: begin
                     state_in = status.area_empty ? ST_IDLE : ST_SETUP;
                  end
                  OP_FG_SPAN: state_in = status.area_empty ? ST_IDLE : ST_WALK;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.box_empty ? ST_IDLE : ST_WALK;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hw/rtl/ccde_datapath.sv */
// ---------------------------------------------------------------------------
// Character-cell draw engine: datapath
// Area registers, walk coordinates, disc test, cell store and response stage.
// ---------------------------------------------------------------------------
module ccde_datapath import ccde_pkg::*; #(
   parameter int MAX_COLS = 80,
   parameter int MAX_ROWS = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [0:0]          csr_addr,
   input  logic [6:0]          csr_wdata,
   input  op_type              req_op,
   input  logic [3:0]          req_color,
   input  logic [7:0]          req_glyph,
   input  logic signed [9:0]   req_x_a,
   input  logic signed [9:0]   req_y_a,
   input  logic signed [9:0]   req_x_b,
   input  logic signed [9:0]   req_y_b,
   input  logic [5:0]          req_radius,
   input  logic [10:0]         req_span_length,
   input  ccde_cmd_type        cmd,
   output ccde_status_type     status,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output logic [7:0]          rsp_cell_glyph,
   output logic [3:0]          rsp_cell_fg,
   output logic [3:0]          rsp_cell_bg,
   output logic                rsp_in_range
);

   localparam int Cells = MAX_COLS * MAX_ROWS;
   localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [6:0]  cols_ff;
   logic [4:0]  rows_ff;
   op_type      op_ff;
   logic [3:0]  color_ff;
   logic [7:0]  glyph_ff;
   coord_type   xa_ff, ya_ff, xb_ff, yb_ff;
   logic [5:0]  radius_ff;
   logic [10:0] len_ff;
   coord_type   x_ff, y_ff, x0_ff, x1_ff, y0_ff, y1_ff;
   logic [12:0] rr_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          s1_paint_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [15:0]   rd_data_ff;
   logic [15:0]   mem [0:Cells-1];
   logic          rsp_valid_ff;
   logic [15:0]   rsp_cell_ff;
   logic          rsp_in_range_ff;

   coord_type w, h, r, lo_x, hi_x, lo_y, hi_y, x0_in, x1_in, y0_in, y1_in;
   coord_type dx, dy, adx, ady, ex, ey, cx, cy;
   logic [11:0] dx_sq, dy_sq;
   logic [12:0] dsum, rr_in;
   logic disc_ok, wrap, span_ok, is_span, paint, in_range;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [15:0]   wr_data, cell_mod;
   logic [7:0]    disc_glyph;

   // drawing area, clamped to the store
   assign w = (int'(cols_ff) > MAX_COLS) ? coord_type'(MAX_COLS) : coord_type'(cols_ff);
   assign h = (int'(rows_ff) > MAX_ROWS) ? coord_type'(MAX_ROWS) : coord_type'(rows_ff);
   assign r = coord_type'(radius_ff);

   // box bounds
   always_comb begin
      if (op_ff == OP_DISC) begin
         lo_x = xa_ff - r;
         hi_x = xa_ff + r;
         lo_y = ya_ff - r;
         hi_y = ya_ff + r;
      end else begin
         lo_x = xa_ff;
         hi_x = xb_ff;
         lo_y = ya_ff;
         hi_y = yb_ff;
      end
      x0_in = lo_x[CoordWidth-1] ? '0 : lo_x;
      y0_in = lo_y[CoordWidth-1] ? '0 : lo_y;
      x1_in = (hi_x > w - coord_type'(1)) ? w - coord_type'(1) : hi_x;
      y1_in = (hi_y > h - coord_type'(1)) ? h - coord_type'(1) : hi_y;
   end

   assign rr_in = {1'b0, 12'(radius_ff * radius_ff)} + 13'd1;

   // disc membership
   assign dx      = x_ff - xa_ff;
   assign dy      = y_ff - ya_ff;
   assign adx     = dx[CoordWidth-1] ? -dx : dx;
   assign ady     = dy[CoordWidth-1] ? -dy : dy;
   assign dx_sq   = 12'(adx[5:0] * adx[5:0]);
   assign dy_sq   = 12'(ady[5:0] * ady[5:0]);
   assign dsum    = {1'b0, dx_sq} + {1'b0, dy_sq};
   assign disc_ok = (dsum <= rr_ff);

   // span position with row wrap
   assign is_span = (op_ff == OP_FG_SPAN);
   assign wrap    = (x_ff >= w);
   assign ex      = wrap ? '0 : x_ff;
   assign ey      = wrap ? y_ff + coord_type'(1) : y_ff;
   assign span_ok = (len_ff != '0) && !ex[CoordWidth-1] && !ey[CoordWidth-1] && (ey < h);

   assign cx = is_span ? ex : x_ff;
   assign cy = is_span ? ey : y_ff;

   always_comb begin
      if (is_span) begin
         paint = span_ok;
      end else if (op_ff == OP_DISC) begin
         paint = disc_ok;
      end else begin
         paint = 1'b1;
      end
   end

   assign in_range = !xa_ff[CoordWidth-1] && (xa_ff < w) && !ya_ff[CoordWidth-1] && (ya_ff < h);

   assign rd_addr = AW'(AW'(cy[YW-1:0]) * AW'(MAX_COLS) + AW'(cx[XW-1:0]));

   assign status.area_empty = (w == '0) || (h == '0);
   assign status.box_empty  = (x0_ff > x1_ff) || (y0_ff > y1_ff);
   assign status.walk_last  = is_span ? (!span_ok || (len_ff == 11'd1))
                                      : ((x_ff == x1_ff) && (y_ff == y1_ff));
   assign status.clear_last = (clr_cnt_ff == AW'(Cells - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   // read-modify-write of one cell
   assign disc_glyph = (glyph_ff == 8'd0) ? SOLID_BLOCK : glyph_ff;
   always_comb begin
      cell_mod = rd_data_ff;
      case (op_ff) inside
         OP_FG_RECT, OP_FG_SPAN: cell_mod[11:8] = color_ff;
         OP_BLOCK_RECT: begin
            cell_mod[11:8] = color_ff;
            cell_mod[7:0]  = SOLID_BLOCK;
         end
         OP_BG_RECT: cell_mod[15:12] = color_ff;
         OP_DISC: begin
            cell_mod[11:8] = color_ff;
            cell_mod[7:0]  = disc_glyph;
         end
         default: cell_mod = rd_data_ff;
      endcase
   end

   assign wr_en   = cmd.clear || s1_paint_ff;
   assign wr_addr = cmd.clear ? clr_cnt_ff : s1_addr_ff;
   assign wr_data = cmd.clear ? 16'd0 : cell_mod;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
         clr_cnt_ff   <= '0;
         s1_paint_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_COLS: cols_ff <= csr_wdata;
               CSR_ROWS: rows_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         s1_paint_ff <= cmd.step && paint;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_addr_ff <= rd_addr;
      if (cmd.load) begin
         op_ff     <= req_op;
         color_ff  <= req_color;
         glyph_ff  <= req_glyph;
         xa_ff     <= coord_type'(req_x_a);
         ya_ff     <= coord_type'(req_y_a);
         xb_ff     <= coord_type'(req_x_b);
         yb_ff     <= coord_type'(req_y_b);
         radius_ff <= req_radius;
         len_ff    <= req_span_length;
         x_ff      <= coord_type'(req_x_a);
         y_ff      <= coord_type'(req_y_a);
      end else if (cmd.setup) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y0_ff <= y0_in;
         y1_ff <= y1_in;
         rr_ff <= rr_in;
         x_ff  <= x0_in;
         y_ff  <= y0_in;
      end else if (cmd.step) begin
         if (is_span) begin
            x_ff   <= ex + coord_type'(1);
            y_ff   <= ey;
            len_ff <= len_ff - 11'd1;
         end else if (x_ff == x1_ff) begin
            x_ff <= x0_ff;
            y_ff <= y_ff + coord_type'(1);
         end else begin
            x_ff <= x_ff + coord_type'(1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff     <= in_range ? rd_data_ff : 16'd0;
         rsp_in_range_ff <= in_range;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_glyph = rsp_cell_ff[7:0];
   assign rsp_cell_fg    = rsp_cell_ff[11:8];
   assign rsp_cell_bg    = rsp_cell_ff[15:12];
   assign rsp_in_range   = rsp_in_range_ff;

endmodule

/* hw/rtl/ccde_checker.sv */
// ---------------------------------------------------------------------------
// Character-cell draw engine: port checker
// Checks the engine's port behaviour over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "char_cell_draw_engine_defines.svh"

module ccde_checker import ccde_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   `CCDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   `CCDE_ASSERT_NOW(a_out_of_range_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 16'd0, "out-of-range read carries data")

   `CCDE_ASSERT_NOW(a_clear_blocks, clock, reset, $fell(reset), !req_tready, "request taken during clearing")

   `CCDE_ASSERT_NEXT(a_read_busy, clock, reset, req_tvalid && req_tready && (req_tuser == OP_READ), !req_tready, "request taken while read pending")

endmodule

bind char_cell_draw_engine ccde_checker u_ccde_checker (.*);
